// ----- src/ect_pkg.sv -----
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types and constants of the exposure countdown timer.
// ----------------------------------------------------------------------------
package ect_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;
   localparam int HoldWidth     = 16;
   localparam int MinutesWidth  = 7;
   localparam int SecondsWidth  = 13;
   localparam int MsWidth       = 16;
   localparam int BuzzWidth     = 12;
   localparam int PhaseWidth    = 14;
   localparam int ReqDataWidth  = 8;
   localparam int RspDataWidth  = 32;

   // register indexes of the configuration port
   localparam logic [CsrIndexWidth-1:0] REG_LONG_PRESS_MS      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_MAX_MINUTES        = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_MS_PER_SECOND      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_BUZZ_ON_FIRST_MS   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_BUZZ_OFF_FIRST_MS  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_BUZZ_ON_SECOND_MS  = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_BUZZ_OFF_SECOND_MS = 3'd6;

   // configuration reset values
   localparam logic [HoldWidth-1:0]    LONG_PRESS_RESET  = 16'd250;
   localparam logic [MinutesWidth-1:0] MAX_MINUTES_RESET = 7'd99;
   localparam logic [MsWidth-1:0]      MS_PER_SEC_RESET  = 16'd1000;
   localparam logic [BuzzWidth-1:0]    BUZZ_ON1_RESET    = 12'd800;
   localparam logic [BuzzWidth-1:0]    BUZZ_OFF1_RESET   = 12'd200;
   localparam logic [BuzzWidth-1:0]    BUZZ_ON2_RESET    = 12'd400;
   localparam logic [BuzzWidth-1:0]    BUZZ_OFF2_RESET   = 12'd600;

   localparam logic [2:0] LONG_STEP  = 3'd5;
   localparam logic [2:0] SHORT_STEP = 3'd1;

   typedef enum logic [1:0] {
      MODE_SET  = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_DONE = 2'd2
   } mode_type;

   typedef struct packed {
      logic [HoldWidth-1:0]    long_press_ms;
      logic [MinutesWidth-1:0] max_minutes;
      logic [MsWidth-1:0]      ms_per_second;
      logic [BuzzWidth-1:0]    buzz_on_first_ms;
      logic [BuzzWidth-1:0]    buzz_off_first_ms;
      logic [BuzzWidth-1:0]    buzz_on_second_ms;
      logic [BuzzWidth-1:0]    buzz_off_second_ms;
   } cfg_type;

   typedef struct packed {
      logic plus_level;
      logic minus_level;
      logic start_level;
      logic reset_level;
   } buttons_type;

   typedef struct packed {
      logic [SecondsWidth-1:0] seconds_shown;
      logic [MinutesWidth-1:0] minutes_shown;
      logic                    finished_led;
      logic                    wait_led;
      logic                    set_led;
      logic                    buzzer_on;
      logic                    relay_on;
      logic [1:0]              mode_now;
   } result_type;

endpackage

// ----- src/ect_csr.sv -----
// ----------------------------------------------------------------------------
// ect_csr
// Configuration register file, written through the csr channel.
// ----------------------------------------------------------------------------
module ect_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [ect_pkg::CsrIndexWidth-1:0]   wr_index,
   input  logic [ect_pkg::CsrDataWidth-1:0]    wr_data,
   output ect_pkg::cfg_type                    cfg
);
   import ect_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_LONG_PRESS_MS:      cfg_in.long_press_ms      = wr_data;
            REG_MAX_MINUTES:        cfg_in.max_minutes        = wr_data[MinutesWidth-1:0];
            REG_MS_PER_SECOND:      cfg_in.ms_per_second      = wr_data;
            REG_BUZZ_ON_FIRST_MS:   cfg_in.buzz_on_first_ms   = wr_data[BuzzWidth-1:0];
            REG_BUZZ_OFF_FIRST_MS:  cfg_in.buzz_off_first_ms  = wr_data[BuzzWidth-1:0];
            REG_BUZZ_ON_SECOND_MS:  cfg_in.buzz_on_second_ms  = wr_data[BuzzWidth-1:0];
            REG_BUZZ_OFF_SECOND_MS: cfg_in.buzz_off_second_ms = wr_data[BuzzWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms      <= LONG_PRESS_RESET;
         cfg_ff.max_minutes        <= MAX_MINUTES_RESET;
         cfg_ff.ms_per_second      <= MS_PER_SEC_RESET;
         cfg_ff.buzz_on_first_ms   <= BUZZ_ON1_RESET;
         cfg_ff.buzz_off_first_ms  <= BUZZ_OFF1_RESET;
         cfg_ff.buzz_on_second_ms  <= BUZZ_ON2_RESET;
         cfg_ff.buzz_off_second_ms <= BUZZ_OFF2_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/ect_core.sv -----
// ----------------------------------------------------------------------------
// ect_core
// Mode controller: button tracking, minute setting, countdown and buzzer
// pattern. State advances once per step.
// ----------------------------------------------------------------------------
module ect_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  ect_pkg::buttons_type buttons,
   input  ect_pkg::cfg_type     cfg,
   output ect_pkg::result_type  result
);
   import ect_pkg::*;

   mode_type                mode_ff, mode_in;
   logic [MinutesWidth-1:0] minutes_ff, minutes_in;
   logic [HoldWidth-1:0]    plus_hold_ff, plus_hold_in;
   logic [HoldWidth-1:0]    minus_hold_ff, minus_hold_in;
   logic                    start_prev_ff, start_prev_in;
   logic                    reset_prev_ff, reset_prev_in;
   logic [SecondsWidth-1:0] seconds_ff, seconds_in;
   logic [MsWidth-1:0]      ms_count_ff, ms_count_in;
   logic [PhaseWidth-1:0]   phase_ff, phase_in;
   logic                    buzz;

   logic                    plus_rel, minus_rel, start_rel, reset_rel;
   logic [2:0]              plus_step, minus_step;
   logic [MinutesWidth:0]   plus_sum;
   logic [MinutesWidth-1:0] min_after_plus, min_after_minus, min_after_reset;
   logic [SecondsWidth-1:0] start_seconds;
   logic [MsWidth-1:0]      ms_limit;
   logic [MsWidth:0]        ms_inc;
   logic [PhaseWidth-1:0]   seg_a, seg_b, seg_c, seg_total;
   logic [PhaseWidth:0]     phase_inc;

   assign plus_rel  = !buttons.plus_level && (plus_hold_ff != '0);
   assign minus_rel = !buttons.minus_level && (minus_hold_ff != '0);
   assign start_rel = !buttons.start_level && start_prev_ff;
   assign reset_rel = !buttons.reset_level && reset_prev_ff;

   assign plus_step  = (plus_hold_ff > cfg.long_press_ms) ? LONG_STEP : SHORT_STEP;
   assign minus_step = (minus_hold_ff > cfg.long_press_ms) ? LONG_STEP : SHORT_STEP;

   // minute adjust chain: plus, minus, reset
   assign plus_sum = {1'b0, minutes_ff} + {{(MinutesWidth-2){1'b0}}, plus_step};

   always_comb begin
      min_after_plus = minutes_ff;
      if (plus_rel) begin
         if (plus_sum >= {1'b0, cfg.max_minutes})
            min_after_plus = cfg.max_minutes;
         else
            min_after_plus = plus_sum[MinutesWidth-1:0];
      end
      min_after_minus = min_after_plus;
      if (minus_rel) begin
         if (min_after_plus == '0)
            min_after_minus = '0;
         else if (min_after_plus >= {{(MinutesWidth-3){1'b0}}, minus_step})
            min_after_minus = min_after_plus - {{(MinutesWidth-3){1'b0}}, minus_step};
         else
            min_after_minus = '0;
      end
      min_after_reset = reset_rel ? '0 : min_after_minus;
   end

   // minutes * 60 as (m << 6) - (m << 2)
   assign start_seconds = ({{(SecondsWidth-MinutesWidth){1'b0}}, min_after_reset} << 6)
                        - ({{(SecondsWidth-MinutesWidth){1'b0}}, min_after_reset} << 2);

   assign ms_limit = (cfg.ms_per_second == '0) ? {{(MsWidth-1){1'b0}}, 1'b1}
                                              : cfg.ms_per_second;
   assign ms_inc   = {1'b0, ms_count_ff} + (MsWidth+1)'(1);

   assign seg_a     = {2'b00, cfg.buzz_on_first_ms};
   assign seg_b     = seg_a + {2'b00, cfg.buzz_off_first_ms};
   assign seg_c     = seg_b + {2'b00, cfg.buzz_on_second_ms};
   assign seg_total = seg_c + {2'b00, cfg.buzz_off_second_ms};
   assign phase_inc = {1'b0, phase_ff} + (PhaseWidth+1)'(1);

   // next state
   always_comb begin
      mode_in    = mode_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      ms_count_in = ms_count_ff;
      phase_in   = phase_ff;
      buzz       = 1'b0;
      case (mode_ff)
         MODE_RUN: begin
            if (ms_count_ff == '0) begin
               if (seconds_ff == '0) begin
                  mode_in  = MODE_DONE;
                  phase_in = '0;
               end else if (buttons.reset_level) begin
                  mode_in    = MODE_SET;
                  minutes_in = '0;
                  seconds_in = '0;
               end else begin
                  seconds_in = seconds_ff - SecondsWidth'(1);
               end
            end
            if (mode_in == MODE_RUN)
               ms_count_in = (ms_inc >= {1'b0, ms_limit}) ? '0 : ms_inc[MsWidth-1:0];
            else
               ms_count_in = '0;
         end
         MODE_DONE: begin
            if (phase_ff == '0 && buttons.reset_level) begin
               mode_in    = MODE_SET;
               minutes_in = '0;
               seconds_in = '0;
               phase_in   = '0;
            end else begin
               buzz = (phase_ff < seg_a) || (phase_ff >= seg_b && phase_ff < seg_c);
               phase_in = (phase_inc >= {1'b0, seg_total}) ? '0 : phase_inc[PhaseWidth-1:0];
            end
         end
         default: begin
            mode_in    = MODE_SET;
            minutes_in = min_after_reset;
            if (start_rel) begin
               mode_in     = MODE_RUN;
               seconds_in  = start_seconds;
               ms_count_in = '0;
            end
         end
      endcase
   end

   always_comb begin
      plus_hold_in  = !buttons.plus_level ? '0 :
                      (plus_hold_ff == '1) ? plus_hold_ff : plus_hold_ff + HoldWidth'(1);
      minus_hold_in = !buttons.minus_level ? '0 :
                      (minus_hold_ff == '1) ? minus_hold_ff : minus_hold_ff + HoldWidth'(1);
      start_prev_in = buttons.start_level;
      reset_prev_in = buttons.reset_level;
   end

   // outputs, taken from the updated state
   always_comb begin
      result.mode_now      = mode_in;
      result.relay_on      = (mode_in == MODE_RUN);
      result.buzzer_on     = buzz;
      result.set_led       = (mode_in == MODE_SET);
      result.wait_led      = (mode_in == MODE_RUN);
      result.finished_led  = (mode_in == MODE_DONE);
      result.minutes_shown = minutes_in;
      result.seconds_shown = seconds_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SET;
         minutes_ff    <= '0;
         plus_hold_ff  <= '0;
         minus_hold_ff <= '0;
         start_prev_ff <= 1'b0;
         reset_prev_ff <= 1'b0;
         seconds_ff    <= '0;
         ms_count_ff   <= '0;
         phase_ff      <= '0;
      end else if (step) begin
         mode_ff       <= mode_in;
         minutes_ff    <= minutes_in;
         plus_hold_ff  <= plus_hold_in;
         minus_hold_ff <= minus_hold_in;
         start_prev_ff <= start_prev_in;
         reset_prev_ff <= reset_prev_in;
         seconds_ff    <= seconds_in;
         ms_count_ff   <= ms_count_in;
         phase_ff      <= phase_in;
      end
   end

endmodule

// ----- src/exposure_countdown_timer.sv -----
// ----------------------------------------------------------------------------
// exposure_countdown_timer
// Set / run / done exposure timer driven by one millisecond tick per
// transaction.
// ----------------------------------------------------------------------------
// Each req transaction is one millisecond tick with the four button levels;
// each yields exactly one rsp transaction with the mode, relay, buzzer, leds,
// minute setting and seconds left after that tick. A transaction is held in
// an input register; when it advances, the controller updates its state and
// the result is written into the output register at that same clock edge, so one
// transaction is taken every clock while rsp_tready is high. Configuration
// writes are accepted at any time (csr_ready is always high) and should only
// be issued while no tick is in flight.
module exposure_countdown_timer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] plus_level, [1] minus_level, [2] start_level, [3] reset_level
   input  logic [ect_pkg::ReqDataWidth-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] mode_now, [2] relay_on, [3] buzzer_on, [4] set_led, [5] wait_led,
   // [6] finished_led, [13:7] minutes_shown, [26:14] seconds_shown
   output logic [ect_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ect_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [ect_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import ect_pkg::*;

   logic        in_valid_ff;
   buttons_type in_data_ff;
   logic        out_valid_ff;
   result_type  out_data_ff;
   logic        advance;
   buttons_type req_buttons;
   cfg_type     cfg;
   result_type  result;

   assign csr_ready = 1'b1;

   ect_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      req_buttons.plus_level  = req_tdata[0];
      req_buttons.minus_level = req_tdata[1];
      req_buttons.start_level = req_tdata[2];
      req_buttons.reset_level = req_tdata[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_buttons;
      end
   end

   ect_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .buttons (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-$bits(result_type)){1'b0}}, out_data_ff};

endmodule
